// File: src/assert_macros.svh
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define LSQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsq assertion failed");

// next-cycle implication, disabled in reset
`define LSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsq assertion failed");

`endif

// File: src/lsq_pkg.sv
// package with codes, widths and result type of the linear scan priority queue
package lsq_pkg;

  // default capacity in entries
  localparam int DEPTH_DEFAULT = 128;

  // field widths
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 32;
  localparam int OCC_W    = 8;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_PEEK   = 2'd1,
    KIND_DELETE = 2'd2
  } kind_t;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // one result word
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] result_value;
    logic [OCC_W-1:0]          occupancy;
  } result_t;

endpackage

// File: src/lsq_channels.sv
// valid/ready channel interfaces for requests and results
interface lsq_req_if;
  import lsq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink (input valid, kind, value, output ready);
endinterface

interface lsq_rsp_if;
  import lsq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] result_value;
  logic [OCC_W-1:0]          occupancy;

  modport source (output valid, status, result_value, occupancy, input ready);
  modport sink (input valid, status, result_value, occupancy, output ready);
endinterface

// File: src/linear_scan_priority_queue.sv
// Top level of the linear scan min-priority queue.
// Channels: req (kind, value) in, rsp (status, result_value, occupancy) out,
// both valid/ready; a word moves at a rising edge with valid and ready high.
// Each request gives exactly one result word. One request is worked at a time:
// req.ready is high only while the sequencer is idle, and drops the cycle after
// a word is accepted.
// Insert, an unused kind or any error goes from accept straight to the
// registered result. Peek runs a scan that reads one entry per cycle from
// the single read port of the entry store, then drains the read pipeline.
// Delete runs the peek scan, then shifts the entries above pos down by one
// place, where pos is the place of the removed minimum; when the minimum was
// the last entry, the shift-down reads nothing and only lowers the count.
// The result sits in an output register, so the next request is taken while a
// finished word still waits on a stalled receiver; a second result then waits
// in the sequencer until the register frees up.
// Reset (rst, synchronous) empties the queue and clears rsp.valid. The store
// is not cleared: entries at and above the count are never read.
`include "assert_macros.svh"

module linear_scan_priority_queue #(
  parameter int DEPTH = lsq_pkg::DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  lsq_req_if.sink   req,
  lsq_rsp_if.source rsp
);
  import lsq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic signed [VALUE_W-1:0] wr_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic signed [VALUE_W-1:0] rd_data;
  logic                      res_valid;
  logic                      res_ready;
  result_t                   res;

  // entry store
  lsq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer
  lsq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp.status       <= res.status;
      rsp.result_value <= res.result_value;
      rsp.occupancy    <= res.occupancy;
    end
  end

  // checks
  `LSQ_ASSERT_NOW(a_err_zero, clk, rst, rsp.valid && (rsp.status != ST_OK), rsp.result_value == '0)
  `LSQ_ASSERT_NOW(a_empty_occ, clk, rst, rsp.valid && (rsp.status == ST_EMPTY), rsp.occupancy == '0)
  `LSQ_ASSERT_NOW(a_full_occ, clk, rst, rsp.valid && (rsp.status == ST_FULL), rsp.occupancy == OCC_W'(DEPTH))
  `LSQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready)

endmodule

// File: src/lsq_mem.sv
// entry store: one write port, one read port, registered read data
module lsq_mem #(
  parameter int DEPTH = lsq_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [$clog2(DEPTH)-1:0]           wr_addr,
  input  logic signed [lsq_pkg::VALUE_W-1:0] wr_data,
  input  logic                               rd_en,
  input  logic [$clog2(DEPTH)-1:0]           rd_addr,
  output logic signed [lsq_pkg::VALUE_W-1:0] rd_data
);
  import lsq_pkg::*;

  logic signed [VALUE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/lsq_ctrl.sv
// sequencer: insert, minimum scan and shift-down over the entry store
module lsq_ctrl #(
  parameter int DEPTH = lsq_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  lsq_req_if.sink                            req,
  output logic                               wr_en,
  output logic [$clog2(DEPTH)-1:0]           wr_addr,
  output logic signed [lsq_pkg::VALUE_W-1:0] wr_data,
  output logic                               rd_en,
  output logic [$clog2(DEPTH)-1:0]           rd_addr,
  input  logic signed [lsq_pkg::VALUE_W-1:0] rd_data,
  output logic                               res_valid,
  input  logic                               res_ready,
  output lsq_pkg::result_t                   res
);
  import lsq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t                    state;
  logic [CW-1:0]             count;
  logic [CW-1:0]             ridx;
  logic                      dvalid;
  logic [AW-1:0]             didx;
  logic signed [VALUE_W-1:0] best_val;
  logic [AW-1:0]             best_pos;
  logic                      del_op;
  logic [STATUS_W-1:0]       rstat;
  logic signed [VALUE_W-1:0] rval;

  logic accept;
  logic full;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(DEPTH));

  // store access: insert writes at the tail, shift writes one place below the read
  assign rd_en   = ((state == S_SCAN) || (state == S_SHIFT)) && (ridx < count);
  assign rd_addr = ridx[AW-1:0];
  assign wr_en   = (accept && (req.kind == KIND_INSERT) && !full) ||
                   ((state == S_SHIFT) && dvalid);
  assign wr_addr = (state == S_SHIFT) ? (didx - AW'(1)) : count[AW-1:0];
  assign wr_data = (state == S_SHIFT) ? rd_data : req.value;

  // result toward the output register
  assign res_valid        = (state == S_DONE);
  assign res.status       = rstat;
  assign res.result_value = rval;
  assign res.occupancy    = OCC_W'(count);

  // sequencer state and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      dvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ridx   <= '0;
            dvalid <= 1'b0;
            del_op <= (req.kind == KIND_DELETE);
            unique case (req.kind)
              KIND_INSERT: begin
                if (full) begin
                  rstat <= ST_FULL;
                  rval  <= '0;
                end else begin
                  count <= count + CW'(1);
                  rstat <= ST_OK;
                  rval  <= req.value;
                end
                state <= S_DONE;
              end
              KIND_PEEK, KIND_DELETE: begin
                if (count == '0) begin
                  rstat <= ST_EMPTY;
                  rval  <= '0;
                  state <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                // unused code: no change, plain ok with zero value
                rstat <= ST_OK;
                rval  <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          dvalid <= rd_en;
          didx   <= ridx[AW-1:0];
          if (rd_en) begin
            ridx <= ridx + CW'(1);
          end
          // strict less keeps the earliest entry on a tie
          if (dvalid && ((didx == '0) || (rd_data < best_val))) begin
            best_val <= rd_data;
            best_pos <= didx;
          end
          if (!rd_en && !dvalid) begin
            rstat <= ST_OK;
            rval  <= best_val;
            if (del_op) begin
              ridx  <= CW'(best_pos) + CW'(1);
              state <= S_SHIFT;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SHIFT: begin
          dvalid <= rd_en;
          didx   <= ridx[AW-1:0];
          if (rd_en) begin
            ridx <= ridx + CW'(1);
          end
          if (!rd_en && !dvalid) begin
            count <= count - CW'(1);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/tb_linear_scan_priority_queue.sv
`timescale 1ns / 1ps
// testbench for linear_scan_priority_queue: queue model scoreboard, random request and result pacing
module tb_linear_scan_priority_queue;
  import lsq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 1100;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  // shadow of the queue contents plus the results still owed by the block
  class pq_scoreboard;
    int capacity;
    int errors;
    logic signed [VALUE_W-1:0] stored[$];
    result_t awaited[$];

    function new(int depth);
      capacity = depth;
      errors = 0;
    endfunction

    // apply one accepted request to the shadow queue and queue its result
    function void accept_request(logic [KIND_W-1:0] kind, logic signed [VALUE_W-1:0] value);
      result_t r;
      int pos;
      r.status = ST_OK;
      r.result_value = '0;
      case (kind)
        KIND_INSERT: begin
          if (stored.size() >= capacity) begin
            r.status = ST_FULL;
          end else begin
            stored.push_back(value);
            r.result_value = value;
          end
        end
        KIND_PEEK, KIND_DELETE: begin
          if (stored.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // first smallest entry wins a tie
            pos = 0;
            for (int i = 1; i < stored.size(); i++) begin
              if (stored[i] < stored[pos]) pos = i;
            end
            r.result_value = stored[pos];
            if (kind == KIND_DELETE) stored.delete(pos);
          end
        end
        default: ;
      endcase
      r.occupancy = OCC_W'(stored.size());
      awaited.push_back(r);
    endfunction

    // compare one result word with the oldest expectation
    function void check_result(logic [STATUS_W-1:0] status,
                               logic signed [VALUE_W-1:0] result_value,
                               logic [OCC_W-1:0] occupancy);
      result_t e;
      if (awaited.size() == 0) begin
        $error("result word with none expected: status %0d value %0d occupancy %0d",
               status, result_value, occupancy);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (status !== e.status) begin
        $error("status mismatch: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (result_value !== e.result_value) begin
        $error("result_value mismatch: expected %0d, got %0d", e.result_value, result_value);
        errors++;
      end
      if (occupancy !== e.occupancy) begin
        $error("occupancy mismatch: expected %0d, got %0d", e.occupancy, occupancy);
        errors++;
      end
    endfunction

    // anything still owed at the end is a failure
    function void close_out();
      if (awaited.size() != 0) begin
        $error("%0d result words never arrived", awaited.size());
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit calm;
  int stall_left;
  int cycle_count;
  int random_done;
  pq_scoreboard sb;

  lsq_req_if req_ch ();
  lsq_rsp_if rsp_ch ();

  linear_scan_priority_queue #(.DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // known values on every input from time zero
  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_INSERT;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    stall_left = 0;
    calm = 1'b0;
    cycle_count = 0;
    sb = new(DEPTH);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL linear_scan_priority_queue");
      $finish;
    end
  end

  // result side: collect words and draw the next stall
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_result(rsp_ch.status, rsp_ch.result_value, rsp_ch.occupancy);
      stall_left = calm ? 0 : $urandom_range(0, 12);
    end
  end

  // result side: ready follows the stall count
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_ch.ready = 1'b0;
      stall_left--;
    end else begin
      rsp_ch.ready = 1'b1;
    end
  end

  // send one request word after a random gap, note it once accepted
  task automatic send(logic [KIND_W-1:0] kind, logic signed [VALUE_W-1:0] value);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid = 1'b1;
    req_ch.kind = kind;
    req_ch.value = value;
    do @(posedge clk); while (!req_ch.ready);
    sb.accept_request(kind, value);
  endtask

  // hold off the sender until every owed result is back
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // value mix: extremes, a narrow band for ties, full range
  function automatic logic signed [VALUE_W-1:0] draw_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 4))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end
    if (pick <= 3) return $signed($urandom_range(0, 8)) - 4;
    return $urandom;
  endfunction

  // kind mix for a given share of inserts, with a few unused codes
  function automatic logic [KIND_W-1:0] draw_kind(int insert_pct);
    if ($urandom_range(0, 99) < 3) return KIND_UNUSED;
    if ($urandom_range(0, 99) < insert_pct) return KIND_INSERT;
    if ($urandom_range(0, 99) < 65) return KIND_DELETE;
    return KIND_PEEK;
  endfunction

  // one random request, counted unless the block just ignores it
  task automatic send_random(int insert_pct);
    logic [KIND_W-1:0] kind;
    kind = draw_kind(insert_pct);
    send(kind, draw_value());
    if (kind != KIND_UNUSED) random_done++;
  endtask

  // stimulus
  initial begin
    int phase;
    int extra;
    bit reached;
    random_done = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty queue, extremes, ties, unused code
    send(KIND_PEEK, 32'sd17);
    send(KIND_DELETE, -32'sd9);
    send(KIND_UNUSED, $urandom);
    send(KIND_INSERT, VAL_MAX);
    send(KIND_INSERT, VAL_MIN);
    send(KIND_INSERT, 0);
    send(KIND_INSERT, -1);
    send(KIND_PEEK, VAL_MAX);
    send(KIND_INSERT, VAL_MIN);
    send(KIND_INSERT, 5);
    send(KIND_INSERT, 5);
    send(KIND_UNUSED, -1);
    send(KIND_DELETE, 0);
    send(KIND_PEEK, 0);
    send(KIND_DELETE, VAL_MIN);
    send(KIND_DELETE, 0);
    send(KIND_DELETE, 0);
    send(KIND_PEEK, 0);
    send(KIND_DELETE, 0);
    send(KIND_DELETE, 0);
    send(KIND_DELETE, 0);
    send(KIND_DELETE, 0);
    send(KIND_PEEK, 0);
    send(KIND_UNUSED, VAL_MIN);
    wait_drained();

    // random: fill past full, drain past empty, then mixed traffic
    phase = 0;
    while (random_done < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      reached = 1'b0;
      extra = 0;
      case (phase % 3)
        0: begin
          while (extra < 4 && random_done < RANDOM_ITEMS) begin
            send_random(85);
            if (sb.stored.size() == DEPTH) reached = 1'b1;
            if (reached) extra++;
          end
        end
        1: begin
          while (extra < 4 && random_done < RANDOM_ITEMS) begin
            send_random(15);
            if (sb.stored.size() == 0) reached = 1'b1;
            if (reached) extra++;
          end
        end
        default: begin
          repeat (60) if (random_done < RANDOM_ITEMS) send_random(50);
        end
      endcase
      wait_drained();
      phase++;
    end

    // settle, then verdict
    calm = 1'b0;
    wait_drained();
    repeat (2 * DEPTH + 10) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("PASS linear_scan_priority_queue");
    end else begin
      $display("FAIL linear_scan_priority_queue");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/lsq_pkg.sv
src/lsq_channels.sv
src/lsq_mem.sv
src/lsq_ctrl.sv
src/linear_scan_priority_queue.sv
tb/tb_linear_scan_priority_queue.sv
